### hw/rtl/slcfr_pkg.sv
// Package for the sync/length/checksum frame receiver.
// Holds the frame constants, the controller state type and the command and status structs.
// Depends on nothing.
package slcfr_pkg;

  localparam int FRAME_LEN = 32;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int ADDR_W    = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

  localparam logic [7:0] SYNC_FIRST  = 8'h43;
  localparam logic [7:0] SYNC_SECOND = 8'h4F;

  typedef enum logic [5:0] {
    ST_HUNT_FIRST  = 6'b000001,
    ST_HUNT_SECOND = 6'b000010,
    ST_LENGTH      = 6'b000100,
    ST_DATA        = 6'b001000,
    ST_CHECK       = 6'b010000,
    ST_REPLAY      = 6'b100000
  } state_t;

  typedef struct packed {
    logic clr;
    logic store;
    logic rep_start;
    logic rep_issue;
  } cmd_t;

  typedef struct packed {
    logic sync_first;
    logic sync_second;
    logic len_ok;
    logic last_store;
    logic sum_ok;
    logic rd_ready;
    logic rd_last;
    logic rd_pend;
  } sts_t;

endpackage

### hw/rtl/slcfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module slcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/slcfr_ctrl.sv
// Controller state machine of the frame receiver: sync hunt, length check, payload, checksum check, replay.
// Depends on slcfr_pkg.
module slcfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  slcfr_pkg::sts_t sts,
  output slcfr_pkg::cmd_t cmd,
  output logic          in_stall
);
  import slcfr_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT_FIRST: begin
        if (in_fire && sts.sync_first) begin
          state_nxt = ST_HUNT_SECOND;
        end
      end
      ST_HUNT_SECOND: begin
        if (in_fire) begin
          state_nxt = sts.sync_second ? ST_LENGTH : ST_HUNT_FIRST;
        end
      end
      ST_LENGTH: begin
        if (in_fire) begin
          if (sts.len_ok) begin
            cmd.clr   = 1'b1;
            state_nxt = ST_DATA;
          end else begin
            state_nxt = ST_HUNT_FIRST;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.store = 1'b1;
          if (sts.last_store) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          if (sts.sum_ok) begin
            cmd.rep_start = 1'b1;
            state_nxt     = ST_REPLAY;
          end else begin
            state_nxt = ST_HUNT_FIRST;
          end
        end
      end
      ST_REPLAY: begin
        if (sts.rd_ready) begin
          cmd.rep_issue = 1'b1;
          if (sts.rd_last) begin
            state_nxt = ST_HUNT_FIRST;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT_FIRST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r == ST_REPLAY);

endmodule

### hw/rtl/slcfr_dp.sv
// Datapath of the frame receiver: byte counter, checksum, payload RAM and output register.
// Depends on slcfr_pkg and slcfr_ram.
module slcfr_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  slcfr_pkg::cmd_t cmd,
  output slcfr_pkg::sts_t sts,
  input  logic [7:0]      in_rx_byte,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      out_payload_byte,
  output logic            out_last_byte
);
  import slcfr_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              rd_pend_r, pend_last_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic [7:0]        rd_data;

  slcfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_rx_byte),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.clr) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (cmd.store) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + in_rx_byte;
    end
    if (cmd.rep_start) begin
      rd_ptr_nxt = '0;
    end else if (cmd.rep_issue) begin
      rd_ptr_nxt = rd_ptr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      rd_ptr_r    <= '0;
      rd_pend_r   <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_pend_r   <= cmd.rep_issue;
      pend_last_r <= sts.rd_last;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_byte_r <= rd_data;
      out_last_r <= pend_last_r;
    end
  end

  assign sts.sync_first  = (in_rx_byte == SYNC_FIRST);
  assign sts.sync_second = (in_rx_byte == SYNC_SECOND);
  assign sts.len_ok      = (in_rx_byte == 8'(FRAME_LEN));
  assign sts.last_store  = (count_r == CNT_W'(FRAME_LEN - 1));
  assign sts.sum_ok      = (in_rx_byte == sum_r);
  assign sts.rd_ready    = !rd_pend_r && (!out_valid_r || !out_stall);
  assign sts.rd_last     = (rd_ptr_r == ADDR_W'(FRAME_LEN - 1));
  assign sts.rd_pend     = rd_pend_r;

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_last_byte    = out_last_r;

endmodule

### hw/rtl/sync_length_checksum_frame_receiver.sv
// The receiver takes one serial byte per input transaction and hunts for the sync pair 'C' 'O',
// then a length byte that must equal FRAME_LEN, then FRAME_LEN payload bytes and a mod-256
// checksum byte. When the checksum matches, in_stall rises and the stored payload is replayed
// from the payload RAM as FRAME_LEN output transactions, the final one with out_last_byte set;
// each replayed byte passes through a RAM read and then the output register, and a new read
// starts only once the previous one has completed, so the input is held for the whole replay,
// which lasts longer while out_stall is high. A mismatched frame is dropped without output.
// The payload RAM needs no clearing after reset.
// Depends on slcfr_pkg, slcfr_ctrl and slcfr_dp.
module sync_length_checksum_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_last_byte
);
  import slcfr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_valid && !in_stall;

  slcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  slcfr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_rx_byte       (in_rx_byte),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_last_byte    (out_last_byte)
  );

  a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rd_pend |-> (!out_valid || !out_stall))
    else $error("RAM read completed while the output register was still held.");

  a_pend_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rd_pend |=> out_valid)
    else $error("Completed RAM read did not reach the output register.");

  a_replay_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("Replay started without an accepted checksum transaction.");

endmodule
